// ===== sv/gfe_pkg.sv =====
// shared constants, types and the glyph font table for the glyph framebuffer engine
// no dependencies; used by gfe_store, gfe_colmask and the top level
package gfe_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COLUMNS   = 132;

    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_W        = PAGE_COUNT * 8;
    localparam int COL_W          = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;

    localparam int FIRST_CODE     = 32;
    localparam int GLYPH_COUNT    = 96;
    localparam int GLYPH_ROWS     = 16;
    localparam int MAX_GLYPH_COLS = 8;
    localparam int GLYPH_BITS     = 136;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_CHAR  = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    // control from the sequencer to the column store
    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } t_store_req;

    // each entry: width byte in the top bits, then low/high row bytes per column
    localparam logic [GLYPH_BITS-1:0] FONT_ROM [GLYPH_COUNT] = '{
        136'h05_00_00_00_00_00_00_00_00_00_00_00_00_00_00_00_00,
        136'h06_00_00_00_00_38_00_FC_0D_FC_0D_38_00_00_00_00_00,
        136'h07_00_00_06_00_1E_00_00_00_00_00_06_00_1E_00_00_00,
        136'h07_40_02_F0_0F_F0_0F_40_02_F0_0F_F0_0F_40_02_00_00,
        136'h07_30_06_78_0E_C8_08_FE_3F_88_09_38_0F_30_06_00_00,
        136'h07_18_06_24_03_A4_01_D8_06_60_09_30_09_18_06_00_00,
        136'h07_00_07_98_0F_FC_08_E4_09_3C_07_98_0F_80_08_00_00,
        136'h05_00_00_00_00_00_00_16_00_0E_00_00_00_00_00_00_00,
        136'h06_00_00_00_00_F0_03_F8_07_0C_0C_04_08_00_00_00_00,
        136'h06_00_00_00_00_04_08_0C_0C_F8_07_F0_03_00_00_00_00,
        136'h08_80_00_A0_02_E0_03_C0_01_C0_01_E0_03_A0_02_80_00,
        136'h07_00_00_80_00_80_00_E0_03_E0_03_80_00_80_00_00_00,
        136'h04_00_00_00_00_00_2C_00_1C_00_00_00_00_00_00_00_00,
        136'h07_80_00_80_00_80_00_80_00_80_00_80_00_80_00_00_00,
        136'h04_00_00_00_00_00_0C_00_0C_00_00_00_00_00_00_00_00,
        136'h07_00_06_00_03_80_01_C0_00_60_00_30_00_18_00_00_00,
        136'h07_F8_07_FC_0F_84_09_C4_08_64_08_FC_0F_F8_07_00_00,
        136'h07_00_00_10_08_18_08_FC_0F_FC_0F_00_08_00_08_00_00,
        136'h07_08_0E_0C_0F_84_09_C4_08_64_08_3C_0C_18_0C_00_00,
        136'h07_08_04_0C_0C_44_08_44_08_44_08_FC_0F_B8_07_00_00,
        136'h07_C0_01_E0_01_30_01_18_09_FC_0F_FC_0F_00_09_00_00,
        136'h07_7C_04_7C_0C_44_08_44_08_44_08_C4_0F_84_07_00_00,
        136'h07_F8_07_FC_0F_44_08_44_08_44_08_CC_0F_88_07_00_00,
        136'h07_0C_00_0C_00_04_0F_84_0F_C4_00_7C_00_3C_00_00_00,
        136'h07_B8_07_FC_0F_44_08_44_08_44_08_FC_0F_B8_07_00_00,
        136'h07_78_04_FC_0C_84_08_84_08_84_08_FC_0F_F8_07_00_00,
        136'h05_00_00_00_00_00_00_30_06_30_06_00_00_00_00_00_00,
        136'h05_00_00_00_00_00_00_30_16_30_0E_00_00_00_00_00_00,
        136'h07_00_00_80_00_C0_01_60_03_30_06_18_0C_08_08_00_00,
        136'h07_00_00_20_01_20_01_20_01_20_01_20_01_20_01_00_00,
        136'h07_00_00_08_08_18_0C_30_06_60_03_C0_01_80_00_00_00,
        136'h07_18_00_1C_00_04_00_84_0D_C4_0D_7C_00_38_00_00_00,
        136'h08_E0_03_10_04_C8_0B_28_0A_28_09_E8_0B_10_02_E0_01,
        136'h07_F0_0F_F8_0F_8C_00_84_00_8C_00_F8_0F_F0_0F_00_00,
        136'h07_04_08_FC_0F_FC_0F_44_08_44_08_FC_0F_B8_07_00_00,
        136'h07_F8_07_FC_0F_04_08_04_08_04_08_1C_0E_18_06_00_00,
        136'h07_04_08_FC_0F_FC_0F_04_08_04_08_FC_0F_F8_07_00_00,
        136'h07_04_08_FC_0F_FC_0F_C4_08_E4_09_0C_0C_1C_0E_00_00,
        136'h07_04_08_FC_0F_FC_0F_C4_08_E4_01_0C_00_1C_00_00_00,
        136'h07_F8_07_FC_0F_04_08_04_08_84_08_9C_0F_98_0F_00_00,
        136'h07_FC_0F_FC_0F_40_00_40_00_40_00_FC_0F_FC_0F_00_00,
        136'h06_00_00_00_00_04_08_FC_0F_FC_0F_04_08_00_00_00_00,
        136'h07_00_06_00_0E_00_08_04_08_FC_0F_FC_07_04_00_00_00,
        136'h07_04_08_FC_0F_FC_0F_C0_00_E0_01_3C_0F_1C_0E_00_00,
        136'h07_04_08_FC_0F_FC_0F_04_08_00_08_00_0C_00_0E_00_00,
        136'h07_FC_0F_F8_0F_70_00_E0_00_70_00_F8_0F_FC_0F_00_00,
        136'h07_FC_0F_F8_0F_70_00_E0_00_C0_01_FC_0F_FC_0F_00_00,
        136'h07_F8_07_FC_0F_04_08_04_08_04_08_FC_0F_F8_07_00_00,
        136'h07_04_08_FC_0F_FC_0F_84_08_84_00_FC_00_78_00_00_00,
        136'h07_F8_07_FC_0F_04_08_04_0E_04_0C_FC_1F_F8_17_00_00,
        136'h07_04_08_FC_0F_FC_0F_84_00_84_01_FC_0F_78_0E_00_00,
        136'h07_18_06_3C_0E_64_08_44_08_C4_08_9C_0F_18_07_00_00,
        136'h07_00_00_1C_00_0C_08_FC_0F_FC_0F_0C_08_1C_00_00_00,
        136'h07_FC_07_FC_0F_00_08_00_08_00_08_FC_0F_FC_07_00_00,
        136'h07_FC_01_FC_03_00_06_00_0C_00_06_FC_03_FC_01_00_00,
        136'h07_FC_0F_FC_07_00_03_80_01_00_03_FC_07_FC_0F_00_00,
        136'h07_0C_0C_3C_0F_F0_03_E0_01_F0_03_3C_0F_0C_0C_00_00,
        136'h07_00_00_3C_00_7C_08_C0_0F_C0_0F_7C_08_3C_00_00_00,
        136'h07_1C_0E_0C_0F_84_09_C4_08_64_08_3C_0C_1C_0E_00_00,
        136'h06_00_00_00_00_FC_0F_FC_0F_04_08_04_08_00_00_00_00,
        136'h07_18_00_30_00_60_00_C0_00_80_01_00_03_00_06_00_00,
        136'h06_00_00_00_00_04_08_04_08_FC_0F_FC_0F_00_00_00_00,
        136'h07_20_00_30_00_18_00_0C_00_18_00_30_00_20_00_00_00,
        136'h08_00_20_00_20_00_20_00_20_00_20_00_20_00_20_00_20,
        136'h05_00_00_00_00_00_00_0E_00_16_00_00_00_00_00_00_00,
        136'h07_00_07_A0_0F_A0_08_A0_08_E0_07_C0_0F_00_08_00_00,
        136'h07_04_00_FC_0F_FC_0F_20_08_20_08_E0_0F_C0_07_00_00,
        136'h07_C0_07_E0_0F_20_08_20_08_20_08_60_0C_40_04_00_00,
        136'h07_C0_07_E0_0F_20_08_24_08_FC_07_FC_0F_00_08_00_00,
        136'h07_C0_07_E0_0F_20_09_20_09_20_09_E0_0D_C0_05_00_00,
        136'h07_00_00_20_08_F8_0F_FC_0F_24_08_2C_00_08_00_00_00,
        136'h07_C0_27_E0_6F_20_48_20_48_C0_7F_E0_3F_20_00_00_00,
        136'h07_04_08_FC_0F_FC_0F_40_00_20_00_E0_0F_C0_0F_00_00,
        136'h06_00_00_00_00_20_08_EC_0F_EC_0F_00_08_00_00_00_00,
        136'h06_00_30_00_70_00_40_20_40_EC_7F_EC_3F_00_00_00_00,
        136'h07_04_08_FC_0F_FC_0F_80_01_C0_03_60_0E_20_0C_00_00,
        136'h06_00_00_00_00_04_08_FC_0F_FC_0F_00_08_00_00_00_00,
        136'h07_E0_0F_E0_0F_60_00_C0_07_60_00_E0_0F_C0_0F_00_00,
        136'h07_20_00_E0_0F_C0_0F_20_00_20_00_E0_0F_C0_0F_00_00,
        136'h07_C0_07_E0_0F_20_08_20_08_20_08_E0_0F_C0_07_00_00,
        136'h07_20_40_E0_7F_C0_7F_20_48_20_08_E0_0F_C0_07_00_00,
        136'h07_C0_07_E0_0F_20_08_20_48_E0_7F_E0_7F_00_40_00_00,
        136'h07_20_08_E0_0F_C0_0F_60_08_20_00_60_00_60_00_00_00,
        136'h07_40_04_E0_0C_A0_09_20_09_20_0B_60_0E_40_04_00_00,
        136'h06_20_00_20_00_F8_07_FC_0F_20_08_20_04_00_00_00_00,
        136'h07_E0_07_E0_0F_00_08_00_08_E0_07_E0_0F_00_08_00_00,
        136'h07_E0_01_E0_03_00_06_00_0C_00_06_E0_03_E0_01_00_00,
        136'h07_E0_07_E0_0F_00_0C_C0_07_00_0C_E0_0F_E0_07_00_00,
        136'h07_60_0C_E0_0E_80_03_00_01_80_03_E0_0E_60_0C_00_00,
        136'h07_E0_47_E0_4F_00_48_00_48_00_68_E0_3F_E0_1F_00_00,
        136'h07_60_0C_20_0E_20_0B_A0_09_E0_08_60_08_20_0C_00_00,
        136'h07_00_00_40_00_40_00_F8_07_BC_0F_04_08_04_08_00_00,
        136'h05_00_00_00_00_00_00_3C_0F_3C_0F_00_00_00_00_00_00,
        136'h07_00_00_04_08_04_08_BC_0F_F8_07_40_00_40_00_00_00,
        136'h07_08_00_0C_00_04_00_0C_00_08_00_0C_00_04_00_00_00,
        136'h03_F0_1F_10_10_F0_1F_00_00_00_00_00_00_00_00_00_00
    };

    // 16 rows of one glyph column, row 0 in bit 0
    function automatic logic [GLYPH_ROWS-1:0] glyph_column(
        input logic [GLYPH_BITS-1:0] glyph,
        input logic [2:0]            col
    );
        int base;
        base = GLYPH_BITS - 9 - 16 * int'(col);
        return {glyph[base-8 -: 8], glyph[base -: 8]};
    endfunction

endpackage

// ===== sv/gfe_store.sv =====
// column store: one word per display column holding every page of that column
// per-column valid bits let a clear blank all columns without a memory write; uses gfe_pkg
module gfe_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gfe_pkg::t_store_req           i_req,
    input  logic [gfe_pkg::STORE_W-1:0]   i_wr_data,
    output logic [gfe_pkg::STORE_W-1:0]   o_rd_data
);

    logic [gfe_pkg::STORE_W-1:0]       r_mem [gfe_pkg::DISPLAY_WIDTH];
    logic [gfe_pkg::STORE_W-1:0]       r_rd_data;
    logic [gfe_pkg::DISPLAY_WIDTH-1:0] r_valid;
    logic                              r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_valid[i_req.rd_addr];
            end
        end
    end

    // a column not written since the last clear reads as blank
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ===== sv/gfe_colmask.sv =====
// places up to 16 glyph rows at a top row into a full column word, dropping rows
// below the frame; rows that run past row 255 wrap round to the top; uses gfe_pkg
module gfe_colmask (
    input  logic [gfe_pkg::GLYPH_ROWS-1:0] i_bits,
    input  logic [7:0]                     i_top_row,
    output logic [gfe_pkg::STORE_W-1:0]    o_mask
);

    always_comb begin
        logic [7:0] row_ofs;
        for (int j = 0; j < gfe_pkg::STORE_W; j++) begin
            // glyph row that lands on frame row j, modulo 256
            row_ofs   = 8'(j) - i_top_row;
            o_mask[j] = (j < gfe_pkg::DISPLAY_HEIGHT)
                        && (row_ofs < 8'(gfe_pkg::GLYPH_ROWS))
                        && i_bits[row_ofs[3:0]];
        end
    end

endmodule

// ===== sv/glyph_framebuffer_engine_unit.sv =====
// monochrome frame store with clear, pixel, glyph and read-back commands
// depends on gfe_pkg, gfe_store and gfe_colmask
//
// Each command word is taken one at a time. A clear is done at the accept.
// A set-pixel goes through accept, column read and column write; for a pixel
// whose column is off the display the read state makes no access and ends.
// A glyph does a column read and write per column on the display and a pass
// through the read state per column off it, up to 8 columns; a code outside
// 32..127 ends at the accept. A page read goes through accept, column read
// and result. Each drawn column is a read-modify-write of one column word.
// The result word sits in an output register; a read command waits for it to
// drain before loading a new one.
module glyph_framebuffer_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pos_x[7:0], pos_y[15:8], char_code[23:16], page_sel[26:24],
    //        column_sel[34:27], zero fill [39:35]
    input  logic [39:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: read_data[7:0]
    output logic [7:0]  m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_WRITE  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]                     r_x, n_x;
    logic [7:0]                     r_y, n_y;
    logic [2:0]                     r_col, n_col;
    logic [2:0]                     r_last, n_last;
    logic [gfe_pkg::GLYPH_BITS-1:0] r_glyph, n_glyph;
    logic                           r_is_glyph, n_is_glyph;
    logic                           r_is_read, n_is_read;
    logic [2:0]                     r_page, n_page;
    logic [7:0]                     r_col_sel, n_col_sel;
    logic                           r_rd_ok, n_rd_ok;
    logic                           r_out_valid, n_out_valid;
    logic [7:0]                     r_out_data, n_out_data;

    gfe_pkg::t_store_req          st_req;
    logic [gfe_pkg::STORE_W-1:0]  st_wr_data;
    logic [gfe_pkg::STORE_W-1:0]  st_rd_data;
    logic [gfe_pkg::STORE_W-1:0]  col_mask;
    logic [gfe_pkg::GLYPH_ROWS-1:0] col_bits;

    gfe_pkg::t_opcode               in_op;
    logic [7:0]                     in_x, in_y, in_code, in_col_sel;
    logic [2:0]                     in_page;
    logic [gfe_pkg::GLYPH_BITS-1:0] rom_glyph;
    logic [7:0]                     rom_width;
    logic [7:0]                     col_x;
    logic                           col_on;
    logic [7:0]                     page_byte;
    logic                           accept;

    gfe_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (st_req),
        .i_wr_data (st_wr_data),
        .o_rd_data (st_rd_data)
    );

    gfe_colmask u_colmask (
        .i_bits    (col_bits),
        .i_top_row (r_y),
        .o_mask    (col_mask)
    );

    assign in_op      = gfe_pkg::t_opcode'(s_axis_tuser);
    assign in_x       = s_axis_tdata[7:0];
    assign in_y       = s_axis_tdata[15:8];
    assign in_code    = s_axis_tdata[23:16];
    assign in_page    = s_axis_tdata[26:24];
    assign in_col_sel = s_axis_tdata[34:27];

    assign rom_glyph  = gfe_pkg::FONT_ROM[7'(in_code - 8'(gfe_pkg::FIRST_CODE))];
    assign rom_width  = rom_glyph[gfe_pkg::GLYPH_BITS-1 -: 8];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign col_x      = r_x + 8'(r_col);
    assign col_on     = 9'(col_x) < 9'(gfe_pkg::DISPLAY_WIDTH);
    assign col_bits   = r_is_glyph ? gfe_pkg::glyph_column(r_glyph, r_col)
                                   : gfe_pkg::GLYPH_ROWS'(1);
    assign st_wr_data = st_rd_data | col_mask;

    always_comb begin
        page_byte = '0;
        for (int p = 0; p < gfe_pkg::PAGE_COUNT; p++) begin
            if (6'(p) == 6'(r_page)) begin
                page_byte = st_rd_data[p*8 +: 8];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_col       = r_col;
        n_last      = r_last;
        n_glyph     = r_glyph;
        n_is_glyph  = r_is_glyph;
        n_is_read   = r_is_read;
        n_page      = r_page;
        n_col_sel   = r_col_sel;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        st_req      = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_x        = in_x;
                    n_y        = in_y;
                    n_page     = in_page;
                    n_col_sel  = in_col_sel;
                    n_col      = '0;
                    n_last     = '0;
                    n_is_glyph = 1'b0;
                    n_is_read  = 1'b0;
                    n_rd_ok    = (9'(in_col_sel) < 9'(gfe_pkg::DISPLAY_WIDTH))
                                 && (9'(in_col_sel) < 9'(gfe_pkg::PAGE_COLUMNS))
                                 && (6'(in_page) < 6'(gfe_pkg::PAGE_COUNT));
                    unique case (in_op)
                        gfe_pkg::OP_CLEAR: begin
                            st_req.clear = 1'b1;
                        end
                        gfe_pkg::OP_PIXEL: begin
                            n_state = S_READ;
                        end
                        gfe_pkg::OP_CHAR: begin
                            n_is_glyph = 1'b1;
                            n_glyph    = rom_glyph;
                            if (in_code >= 8'(gfe_pkg::FIRST_CODE)
                                && in_code < 8'(gfe_pkg::FIRST_CODE + gfe_pkg::GLYPH_COUNT)
                                && rom_width != 8'd0) begin
                                // widths above eight are cut to eight columns
                                if (rom_width > 8'(gfe_pkg::MAX_GLYPH_COLS)) begin
                                    n_last = 3'(gfe_pkg::MAX_GLYPH_COLS - 1);
                                end else begin
                                    n_last = 3'(rom_width - 8'd1);
                                end
                                n_state = S_READ;
                            end
                        end
                        gfe_pkg::OP_READ: begin
                            n_is_read = 1'b1;
                            n_state   = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_is_read) begin
                    st_req.rd_en   = 1'b1;
                    st_req.rd_addr = gfe_pkg::COL_W'(r_col_sel);
                    n_state        = S_RESULT;
                end else if (col_on) begin
                    st_req.rd_en   = 1'b1;
                    st_req.rd_addr = gfe_pkg::COL_W'(col_x);
                    n_state        = S_WRITE;
                end else if (r_col == r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_col = r_col + 3'd1;
                end
            end
            S_WRITE: begin
                st_req.wr_en   = 1'b1;
                st_req.wr_addr = gfe_pkg::COL_W'(col_x);
                if (r_col == r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_col   = r_col + 3'd1;
                    n_state = S_READ;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_ok ? page_byte : 8'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_col      <= n_col;
        r_last     <= n_last;
        r_glyph    <= n_glyph;
        r_is_glyph <= n_is_glyph;
        r_is_read  <= n_is_read;
        r_page     <= n_page;
        r_col_sel  <= n_col_sel;
        r_rd_ok    <= n_rd_ok;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // every column write lands on the column read in the cycle before
    a_rmw_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_req.wr_en |-> ($past(st_req.rd_en) && st_req.wr_addr == $past(st_req.rd_addr)))
        else $error("column write without matching read");

    // a result word only follows a read command
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_RESULT) && $past(r_is_read))
        else $error("result word without a read command");

    // drawing never touches the store while a read-back is in progress
    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> !st_req.wr_en && !st_req.clear)
        else $error("store modified during read-back");
`endif

endmodule
